>>> rtl/core/kfl_pkg.sv
// ----------------------------------------------------------------------------
// kfl_pkg
// Shared widths, register indexes and word types of the keyframe
// interpolator.
// ----------------------------------------------------------------------------
package kfl_pkg;

    localparam int FRAME_BITS    = 12;
    localparam int WRAP_DURATION = 16;
    localparam int VAL_BITS      = 16;
    localparam int REM_BITS      = FRAME_BITS + 1;
    localparam int PROD_BITS     = VAL_BITS + REM_BITS;
    localparam int SUM_BITS      = PROD_BITS + 1;
    localparam int MAG_BITS      = VAL_BITS + FRAME_BITS;
    localparam int DIV_STEP      = 4;
    localparam int DIV_STAGES    = (MAG_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int QUO_BITS      = DIV_STAGES * DIV_STEP;
    localparam int LANES         = 3;
    localparam int LANE_TRANS    = 0;
    localparam int LANE_ROT      = 1;
    localparam int LANE_SCALE    = 2;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0]  REG_WRAP_THR   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0]  REG_FULL_TURN  = CFG_IDX_BITS'(1);
    localparam logic [CFG_DATA_BITS-1:0] WRAP_THR_RST   = CFG_DATA_BITS'(2048);
    localparam logic [CFG_DATA_BITS-1:0] FULL_TURN_RST  = CFG_DATA_BITS'(4096);
    localparam logic [FRAME_BITS-1:0]    WRAP_DUR       = FRAME_BITS'(WRAP_DURATION);

    typedef logic [FRAME_BITS-1:0]      t_frame;
    typedef logic signed [VAL_BITS-1:0] t_val;

    typedef struct packed {
        t_frame frame;
        t_frame duration;
        t_val   trans_next;
        t_val   trans_prev;
        t_val   rot_next;
        t_val   rot_prev;
        t_val   scale_next;
        t_val   scale_prev;
    } t_in_word;

    typedef struct packed {
        t_frame                           dur;
        logic                             zero;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0][MAG_BITS-1:0]   mag;
    } t_mid;

    typedef struct packed {
        t_val trans_out;
        t_val rot_out;
        t_val scale_out;
        logic no_segment;
    } t_out_word;

endpackage

>>> rtl/core/kfl_ifs.sv
// ----------------------------------------------------------------------------
// kfl interfaces
// Keyframe input channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface kfl_in_if import kfl_pkg::*; ();
    logic   valid;
    logic   ready;
    t_frame frame;
    t_frame duration;
    t_val   trans_next;
    t_val   trans_prev;
    t_val   rot_next;
    t_val   rot_prev;
    t_val   scale_next;
    t_val   scale_prev;

    modport source (
        output valid, frame, duration, trans_next, trans_prev,
               rot_next, rot_prev, scale_next, scale_prev,
        input  ready
    );
    modport sink (
        input  valid, frame, duration, trans_next, trans_prev,
               rot_next, rot_prev, scale_next, scale_prev,
        output ready
    );
endinterface

interface kfl_out_if import kfl_pkg::*; ();
    logic valid;
    logic ready;
    t_val trans_out;
    t_val rot_out;
    t_val scale_out;
    logic no_segment;

    modport source (
        output valid, trans_out, rot_out, scale_out, no_segment,
        input  ready
    );
    modport sink (
        input  valid, trans_out, rot_out, scale_out, no_segment,
        output ready
    );
endinterface

interface kfl_cfg_if import kfl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink (input valid, idx, data, output ready);
endinterface

>>> rtl/core/keyframe_lerp_with_angle_wrap.sv
// ----------------------------------------------------------------------------
// keyframe_lerp_with_angle_wrap
// One animation axis a word: frame, duration and the next and previous
// translation, rotation and scale keys in; the interpolated values out.
//
// i_kf carries input words, o_kf the results, i_cfg writes the wrap
// threshold (index 0) and the full-turn angle (index 1); i_cfg is always
// ready. Each value is (next*frame + prev*(duration-frame)) / duration,
// truncated toward zero and cut to 16 bits. With duration 16 the previous
// angle may first move by one turn. Duration 0 sets no_segment and zero
// values.
// The pipeline has 11 register stages: three front stages (wrap,
// multiply, magnitude), seven divider stages of four quotient bits each,
// and the output register. One word is accepted every cycle while no
// stage is stalled.
// Reset clears all valid bits and loads threshold 2048 and full turn 4096.
// When the receiver stalls, each stage holds its word; i_kf.ready stays
// high until the bubbles in the pipeline are filled, then drops.
// ----------------------------------------------------------------------------
module keyframe_lerp_with_angle_wrap import kfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kfl_in_if.sink    i_kf,
    kfl_out_if.source o_kf,
    kfl_cfg_if.sink   i_cfg
);

    logic [CFG_DATA_BITS-1:0] r_wrap_thr;
    logic [CFG_DATA_BITS-1:0] r_full_turn;

    t_in_word  in_word;
    t_mid      mid;
    logic      mid_valid;
    logic      mid_ready;
    t_out_word out_word;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_thr  <= WRAP_THR_RST;
            r_full_turn <= FULL_TURN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                REG_WRAP_THR:  r_wrap_thr  <= i_cfg.data;
                REG_FULL_TURN: r_full_turn <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign in_word.frame      = i_kf.frame;
    assign in_word.duration   = i_kf.duration;
    assign in_word.trans_next = i_kf.trans_next;
    assign in_word.trans_prev = i_kf.trans_prev;
    assign in_word.rot_next   = i_kf.rot_next;
    assign in_word.rot_prev   = i_kf.rot_prev;
    assign in_word.scale_next = i_kf.scale_next;
    assign in_word.scale_prev = i_kf.scale_prev;

    kfl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_kf.valid),
        .o_ready     (i_kf.ready),
        .i_word      (in_word),
        .i_wrap_thr  (r_wrap_thr),
        .i_full_turn (r_full_turn),
        .o_valid     (mid_valid),
        .i_ready     (mid_ready),
        .o_mid       (mid)
    );

    kfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_mid   (mid),
        .o_valid (o_kf.valid),
        .i_ready (o_kf.ready),
        .o_word  (out_word)
    );

    assign o_kf.trans_out  = out_word.trans_out;
    assign o_kf.rot_out    = out_word.rot_out;
    assign o_kf.scale_out  = out_word.scale_out;
    assign o_kf.no_segment = out_word.no_segment;

endmodule

>>> rtl/core/kfl_front.sv
// ----------------------------------------------------------------------------
// kfl_front
// Angle wrap, weights, per-lane products and signed numerator magnitude,
// three register stages.
// ----------------------------------------------------------------------------
module kfl_front import kfl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_in_word                 i_word,
    input  logic [CFG_DATA_BITS-1:0] i_wrap_thr,
    input  logic [CFG_DATA_BITS-1:0] i_full_turn,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_mid                     o_mid
);

    localparam int NS = 3;

    logic [NS-1:0] r_vld;
    logic [NS:0]   stg_rdy;

    // stage 0: wrap and remaining weight
    t_frame                      r0_t;
    t_frame                      r0_dur;
    logic                        r0_zero;
    logic signed [REM_BITS-1:0]  r0_rem;
    t_val                        r0_nxt [LANES];
    t_val                        r0_prv [LANES];

    // stage 1: products
    t_frame                      r1_dur;
    logic                        r1_zero;
    logic signed [PROD_BITS-1:0] r1_pn [LANES];
    logic signed [PROD_BITS-1:0] r1_pp [LANES];

    // stage 2: magnitude and sign
    t_mid                        r2_mid;

    logic [VAL_BITS:0]           rot_diff;
    logic [VAL_BITS:0]           rot_adiff;
    logic                        do_wrap;
    logic [VAL_BITS-1:0]         rot_prev_w;
    logic signed [REM_BITS-1:0]  n0_rem;
    logic signed [PROD_BITS-1:0] n1_pn [LANES];
    logic signed [PROD_BITS-1:0] n1_pp [LANES];
    t_mid                        n2_mid;

    always_comb begin
        stg_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_mid   = r2_mid;

    always_comb begin
        rot_diff  = {i_word.rot_next[VAL_BITS-1], i_word.rot_next}
                  - {i_word.rot_prev[VAL_BITS-1], i_word.rot_prev};
        rot_adiff = rot_diff[VAL_BITS] ? (VAL_BITS+1)'(-rot_diff) : rot_diff;
        do_wrap   = (i_word.duration == WRAP_DUR) && (rot_adiff >= {1'b0, i_wrap_thr});
        if (!do_wrap) begin
            rot_prev_w = i_word.rot_prev;
        end else if (i_word.rot_prev[VAL_BITS-1] || (i_word.rot_prev == '0)) begin
            rot_prev_w = i_word.rot_prev + i_full_turn;
        end else begin
            rot_prev_w = i_word.rot_prev - i_full_turn;
        end
        n0_rem = $signed({1'b0, i_word.duration}) - $signed({1'b0, i_word.frame});
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n1_pn[l] = PROD_BITS'(r0_nxt[l]) * PROD_BITS'($signed({1'b0, r0_t}));
            n1_pp[l] = PROD_BITS'(r0_prv[l]) * PROD_BITS'(r0_rem);
        end
    end

    always_comb begin
        logic signed [SUM_BITS-1:0] sum;
        logic [SUM_BITS-1:0]        amag;
        n2_mid.dur  = r1_dur;
        n2_mid.zero = r1_zero;
        for (int l = 0; l < LANES; l++) begin
            sum            = SUM_BITS'(r1_pn[l]) + SUM_BITS'(r1_pp[l]);
            amag           = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
            n2_mid.neg[l]  = sum[SUM_BITS-1];
            n2_mid.mag[l]  = amag[MAG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r0_t              <= i_word.frame;
            r0_dur            <= i_word.duration;
            r0_zero           <= (i_word.duration == '0);
            r0_rem            <= n0_rem;
            r0_nxt[LANE_TRANS] <= i_word.trans_next;
            r0_prv[LANE_TRANS] <= i_word.trans_prev;
            r0_nxt[LANE_ROT]   <= i_word.rot_next;
            r0_prv[LANE_ROT]   <= rot_prev_w;
            r0_nxt[LANE_SCALE] <= i_word.scale_next;
            r0_prv[LANE_SCALE] <= i_word.scale_prev;
        end
        if (stg_rdy[1]) begin
            r1_dur  <= r0_dur;
            r1_zero <= r0_zero;
            r1_pn   <= n1_pn;
            r1_pp   <= n1_pp;
        end
        if (stg_rdy[2]) begin
            r2_mid <= n2_mid;
        end
    end

endmodule

>>> rtl/core/kfl_div.sv
// ----------------------------------------------------------------------------
// kfl_div
// Pipelined restoring divider for the three lanes, four quotient bits a
// stage, then sign restore and the output register.
// ----------------------------------------------------------------------------
module kfl_div import kfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_mid      i_mid,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    localparam int NS = DIV_STAGES + 1;

    logic [NS-1:0]       r_vld;
    logic [NS:0]         stg_rdy;

    logic [FRAME_BITS-1:0] r_rem  [DIV_STAGES][LANES];
    logic [QUO_BITS-1:0]   r_num  [DIV_STAGES][LANES];
    t_frame                r_dur  [DIV_STAGES];
    logic                  r_zero [DIV_STAGES];
    logic [LANES-1:0]      r_neg  [DIV_STAGES];
    t_out_word             r_out;

    logic [FRAME_BITS-1:0] n_rem  [DIV_STAGES][LANES];
    logic [QUO_BITS-1:0]   n_num  [DIV_STAGES][LANES];
    t_out_word             n_out;

    always_comb begin
        stg_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_word  = r_out;

    always_comb begin
        logic [FRAME_BITS-1:0] c_rem;
        logic [QUO_BITS-1:0]   c_num;
        logic [FRAME_BITS:0]   c_p;
        t_frame                c_dur;
        for (int k = 0; k < DIV_STAGES; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    c_rem = '0;
                    c_num = QUO_BITS'(i_mid.mag[l]);
                    c_dur = i_mid.dur;
                end else begin
                    c_rem = r_rem[k-1][l];
                    c_num = r_num[k-1][l];
                    c_dur = r_dur[k-1];
                end
                for (int s = 0; s < DIV_STEP; s++) begin
                    c_p = {c_rem, c_num[QUO_BITS-1]};
                    if (c_p >= {1'b0, c_dur}) begin
                        c_rem = FRAME_BITS'(c_p - {1'b0, c_dur});
                        c_num = {c_num[QUO_BITS-2:0], 1'b1};
                    end else begin
                        c_rem = c_p[FRAME_BITS-1:0];
                        c_num = {c_num[QUO_BITS-2:0], 1'b0};
                    end
                end
                n_rem[k][l] = c_rem;
                n_num[k][l] = c_num;
            end
        end
    end

    always_comb begin
        t_val q [LANES];
        for (int l = 0; l < LANES; l++) begin
            q[l] = r_num[DIV_STAGES-1][l][VAL_BITS-1:0];
            if (r_zero[DIV_STAGES-1]) begin
                q[l] = '0;
            end else if (r_neg[DIV_STAGES-1][l]) begin
                q[l] = -q[l];
            end
        end
        n_out.trans_out  = q[LANE_TRANS];
        n_out.rot_out    = q[LANE_ROT];
        n_out.scale_out  = q[LANE_SCALE];
        n_out.no_segment = r_zero[DIV_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_dur[0]  <= i_mid.dur;
            r_zero[0] <= i_mid.zero;
            r_neg[0]  <= i_mid.neg;
            r_rem[0]  <= n_rem[0];
            r_num[0]  <= n_num[0];
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (stg_rdy[k]) begin
                r_dur[k]  <= r_dur[k-1];
                r_zero[k] <= r_zero[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_rem[k]  <= n_rem[k];
                r_num[k]  <= n_num[k];
            end
        end
        if (stg_rdy[NS-1]) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_rem_chk
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            a_rem_below_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                r_vld[k] && !r_zero[k] |-> r_rem[k][l] < r_dur[k])
                else $error("partial remainder not below divisor");
        end
    end

    a_no_seg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && r_out.no_segment |->
            r_out.trans_out == '0 && r_out.rot_out == '0 && r_out.scale_out == '0)
        else $error("empty segment word carries nonzero values");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-2] && r_zero[DIV_STAGES-1] && stg_rdy[NS-1] |=> r_out.no_segment)
        else $error("empty segment flag lost at output register");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !stg_rdy[1] |=> r_vld[0] && $stable(r_dur[0]))
        else $error("stalled divider word dropped");
`endif

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyframe_lerp_with_angle_wrap. Directed corner
// words, register sweeps and random traffic go in through a bursty sender.
// The receiver stalls in changing patterns. Every result word is checked
// against an in-bench interpolation with the same angle wrap rules.
// ----------------------------------------------------------------------------
module tb_top;
    import kfl_pkg::*;

    localparam int PIPE_LATENCY   = 11;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(8'hA5);
    localparam t_frame FRAME_TOP = '1;
    localparam t_val   VAL_MAX   = 16'sh7FFF;
    localparam t_val   VAL_MIN   = 16'sh8000;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BEAT, RX_CHOKE} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    kfl_in_if  kf_in ();
    kfl_out_if kf_out ();
    kfl_cfg_if kf_cfg ();

    keyframe_lerp_with_angle_wrap DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kf    (kf_in),
        .o_kf    (kf_out),
        .i_cfg   (kf_cfg)
    );

    t_out_word          axis_expect_q[$];
    logic [15:0]        wrap_thr_sh;
    logic [15:0]        full_turn_sh;
    int                 mismatch_cnt;
    int                 idle_cycles;
    int                 burst_left;
    t_rx_mode           rx_mode;
    int                 rx_mode_left;
    int unsigned        rx_phase;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // interpolation of one axis
    // ------------------------------------------------------------------
    function automatic t_val lane_quot(input longint nxt, input longint prv,
                                       input longint t, input longint rem,
                                       input longint dur);
        longint q;
        q = (nxt * t + prv * rem) / dur;
        return t_val'(q[15:0]);
    endfunction

    function automatic t_out_word interpolate_axis(input t_in_word w,
                                                   input logic [15:0] thr,
                                                   input logic [15:0] turn);
        t_out_word r;
        longint    t;
        longint    dur;
        longint    rem;
        longint    rn;
        longint    rp;
        longint    d;
        longint    wv;
        r   = '0;
        t   = longint'(w.frame);
        dur = longint'(w.duration);
        if (dur == 0) begin
            r.no_segment = 1'b1;
            return r;
        end
        rn = longint'(w.rot_next);
        rp = longint'(w.rot_prev);
        // short way round, only for the wrap duration
        if (dur == WRAP_DURATION) begin
            d = rn - rp;
            if (d < 0) d = -d;
            if (d >= longint'(thr)) begin
                wv = (rp <= 0) ? rp + longint'(turn) : rp - longint'(turn);
                rp = longint'(t_val'(wv[15:0]));
            end
        end
        rem = dur - t;
        r.trans_out = lane_quot(longint'(w.trans_next), longint'(w.trans_prev),
                                t, rem, dur);
        r.rot_out   = lane_quot(rn, rp, t, rem, dur);
        r.scale_out = lane_quot(longint'(w.scale_next), longint'(w.scale_prev),
                                t, rem, dur);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // monitor: register shadow, expected words, result check, watchdog
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_in_word  w;
        t_out_word e;
        if (!i_rst_n) begin
            wrap_thr_sh  = WRAP_THR_RST;
            full_turn_sh = FULL_TURN_RST;
            idle_cycles  = 0;
        end else begin
            if (kf_cfg.valid && kf_cfg.ready) begin
                case (kf_cfg.idx)
                    REG_WRAP_THR:  wrap_thr_sh  = kf_cfg.data;
                    REG_FULL_TURN: full_turn_sh = kf_cfg.data;
                    default: ;
                endcase
            end
            if (kf_in.valid && kf_in.ready) begin
                w = '{kf_in.frame, kf_in.duration, kf_in.trans_next, kf_in.trans_prev,
                      kf_in.rot_next, kf_in.rot_prev, kf_in.scale_next,
                      kf_in.scale_prev};
                axis_expect_q.push_back(interpolate_axis(w, wrap_thr_sh, full_turn_sh));
            end
            if (kf_out.valid && kf_out.ready) begin
                if (axis_expect_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %0d %0d %0d %0d",
                             $time, kf_out.trans_out, kf_out.rot_out, kf_out.scale_out,
                             kf_out.no_segment);
                    mismatch_cnt++;
                end else begin
                    e = axis_expect_q.pop_front();
                    check_field("trans_out", e.trans_out, kf_out.trans_out);
                    check_field("rot_out", e.rot_out, kf_out.rot_out);
                    check_field("scale_out", e.scale_out, kf_out.scale_out);
                    check_field("no_segment", e.no_segment, kf_out.no_segment);
                end
            end
            if ((kf_in.valid && kf_in.ready) || (kf_out.valid && kf_out.ready) ||
                (kf_cfg.valid && kf_cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** keyframe_lerp_with_angle_wrap: FAILED **");
                $finish;
            end
        end
    end

    // receiver stall patterns
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 300);
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   kf_out.ready <= 1'b1;
            RX_RANDOM: kf_out.ready <= ($urandom_range(0, 3) != 0);
            RX_BEAT:   kf_out.ready <= ((rx_phase % 7) < 4);
            default:   kf_out.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_axis(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                kf_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        kf_in.valid      <= 1'b1;
        kf_in.frame      <= w.frame;
        kf_in.duration   <= w.duration;
        kf_in.trans_next <= w.trans_next;
        kf_in.trans_prev <= w.trans_prev;
        kf_in.rot_next   <= w.rot_next;
        kf_in.rot_prev   <= w.rot_prev;
        kf_in.scale_next <= w.scale_next;
        kf_in.scale_prev <= w.scale_prev;
        do @(posedge i_clk); while (!kf_in.ready);
    endtask

    // stop sending and wait for every pending result word
    task automatic drain_pipe();
        kf_in.valid <= 1'b0;
        while (axis_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        kf_cfg.valid <= 1'b1;
        kf_cfg.idx   <= idx;
        kf_cfg.data  <= data;
        do @(posedge i_clk); while (!kf_cfg.ready);
        kf_cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_val rand_val();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return t_val'(int'($urandom_range(0, 64)) - 32);
            default: return t_val'($urandom);
        endcase
    endfunction

    function automatic t_in_word rand_axis();
        t_in_word w;
        int       pick;
        int       delta;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            w.duration = '0;
        else if (pick <= 6)
            w.duration = WRAP_DUR;
        else if (pick <= 11)
            w.duration = t_frame'($urandom_range(1, 40));
        else
            w.duration = t_frame'($urandom);
        if ($urandom_range(0, 9) == 0)
            w.frame = t_frame'($urandom);
        else
            w.frame = t_frame'($urandom_range(0, w.duration));
        w.trans_next = rand_val();
        w.trans_prev = rand_val();
        w.rot_next   = rand_val();
        w.rot_prev   = rand_val();
        w.scale_next = rand_val();
        w.scale_prev = rand_val();
        // angle pairs around the current threshold
        if (w.duration == WRAP_DUR && $urandom_range(0, 1) == 1) begin
            delta = int'(wrap_thr_sh) + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 1) == 1) delta = -delta;
            w.rot_next = t_val'(int'(w.rot_prev) + delta);
        end
        return w;
    endfunction

    task automatic run_items(input int n);
        repeat (n) send_axis(rand_axis());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_extremes();
        // zero duration
        send_axis('{FRAME_TOP, 12'd0, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN});
        send_axis('{12'd0, 12'd0, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1});
        // frame at the segment ends
        send_axis('{12'd0, 12'd1, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN});
        send_axis('{12'd1, 12'd1, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX});
        send_axis('{FRAME_TOP, FRAME_TOP, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX,
                    VAL_MIN});
        // frame beyond duration
        send_axis('{FRAME_TOP, 12'd1, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX});
        send_axis('{FRAME_TOP, 12'd2, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN});
        send_axis('{12'd5, 12'd3, 16'sd100, -16'sd100, 16'sd7, 16'sd9, -16'sd5, 16'sd3});
        // angle wrap at the wrap duration
        send_axis('{12'd4, WRAP_DUR, 16'sd100, -16'sd100, 16'sd2048, 16'sd0, 16'sd10,
                    16'sd20});
        send_axis('{12'd8, WRAP_DUR, 16'sd1, 16'sd2, 16'sd2047, 16'sd0, 16'sd3, 16'sd4});
        send_axis('{12'd8, WRAP_DUR, 16'sd5, 16'sd6, -16'sd3000, 16'sd100, 16'sd7, 16'sd8});
        send_axis('{12'd15, WRAP_DUR, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX});
        send_axis('{12'd1, WRAP_DUR, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN});
        send_axis('{12'd0, WRAP_DUR, 16'sd9, -16'sd9, 16'sd2047, -16'sd1, 16'sd0, 16'sd0});
        send_axis('{12'd16, WRAP_DUR, 16'sd0, 16'sd0, -16'sd2048, 16'sd1, 16'sd2, 16'sd2});
        // no wrap next to the wrap duration
        send_axis('{12'd16, 12'd17, 16'sd11, 16'sd12, 16'sd3000, -16'sd3000, 16'sd1,
                    16'sd1});
        send_axis('{12'd7, 12'd15, 16'sd11, 16'sd12, 16'sd3000, -16'sd3000, 16'sd1,
                    16'sd1});
        // bit patterns
        send_axis('{12'h555, 12'hAAA, 16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556,
                    16'sh5555, -16'sh5556});
        send_axis('{12'hAAA, 12'h555, -16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555,
                    -16'sh5556, 16'sh5555});
        send_axis('{12'd2048, FRAME_TOP, 16'sh1234, -16'sh1234, 16'sd0, 16'sd0, VAL_MAX,
                    VAL_MAX});
        send_axis('{12'd3, 12'd10, 16'sd7, -16'sd7, 16'sd100, 16'sd200, 16'sd1, -16'sd1});
        drain_pipe();
    endtask

    task automatic apply_setting(input logic [15:0] thr, input logic [15:0] turn);
        drain_pipe();
        write_reg(REG_WRAP_THR, thr);
        write_reg(REG_FULL_TURN, turn);
        run_items(50);
    endtask

    task automatic test_register_settings();
        apply_setting(16'd0, 16'hFFFF);
        apply_setting(16'hFFFF, 16'd0);
        apply_setting(16'd1, 16'd1);
        apply_setting(16'd0, 16'd0);
        drain_pipe();
        // unmapped index leaves both registers alone
        write_reg(REG_SPARE, 16'hFFFF);
        apply_setting(16'd2048, 16'd4096);
        drain_pipe();
    endtask

    task automatic test_random_traffic();
        repeat (4) begin
            drain_pipe();
            write_reg(REG_WRAP_THR, 16'($urandom_range(0, 6000)));
            write_reg(REG_FULL_TURN, 16'($urandom));
            run_items(300);
        end
        drain_pipe();
    endtask

    initial begin
        burst_left         = 0;
        i_rst_n           <= 1'b0;
        kf_in.valid       <= 1'b0;
        kf_in.frame       <= '0;
        kf_in.duration    <= '0;
        kf_in.trans_next  <= '0;
        kf_in.trans_prev  <= '0;
        kf_in.rot_next    <= '0;
        kf_in.rot_prev    <= '0;
        kf_in.scale_next  <= '0;
        kf_in.scale_prev  <= '0;
        kf_cfg.valid      <= 1'b0;
        kf_cfg.idx        <= '0;
        kf_cfg.data       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_register_settings();
        test_random_traffic();

        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_cnt == 0 && axis_expect_q.size() == 0) begin
            $display("** keyframe_lerp_with_angle_wrap: PASSED **");
        end else begin
            $display("** keyframe_lerp_with_angle_wrap: FAILED **");
        end
        $finish;
    end

endmodule
